>>> hdl/hrl_pkg.sv
// shared types, constants and weight table for the radial low-pass filter
package hrl_pkg;

    localparam int unsigned SampleW = 16;
    localparam int unsigned CountW  = 32;
    localparam int unsigned WidthW  = 12;
    localparam int unsigned HeightW = 16;
    localparam int unsigned WeightW = 11;
    localparam int unsigned DenW    = 13;

    // register indexes of the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ENABLE = 2'd2;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [WidthW-1:0]  width;
        logic [HeightW-1:0] height;
        logic               enable;
    } t_cfg;

    // one output pixel job handed from front to back
    typedef struct packed {
        logic [CountW-1:0] pix;
        logic [CountW-1:0] wptr;
        logic              last;
    } t_job;

    // Q1.10 weight by absolute row and column offset
    function automatic logic [WeightW-1:0] tap_weight(input logic [1:0] ady,
                                                      input logic [1:0] adx);
        logic [WeightW-1:0] wt;
        wt = '0;
        unique case ({ady, adx})
            4'b0000: wt = 11'd1024;
            4'b0001, 4'b0100: wt = 11'd614;
            4'b0010, 4'b1000: wt = 11'd205;
            4'b0101: wt = 11'd445;
            4'b0110, 4'b1001: wt = 11'd108;
            default: wt = 11'd0;
        endcase
        return wt;
    endfunction

endpackage

>>> hdl/hrl_ram.sv
// generic single-port-write, single-port-read ram with registered read
module hrl_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 8200
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> hdl/hrl_fifo.sv
// two-entry job queue between front and back
module hrl_fifo
    import hrl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
endmodule

>>> hdl/hrl_div.sv
// restoring divider, one quotient bit per cycle, 32-bit by 13-bit
module hrl_div
    import hrl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CountW-1:0] i_dividend,
    input  logic [DenW-1:0]   i_divisor,
    output logic              o_busy,
    output logic              o_done,
    output logic [CountW-1:0] o_quot,
    output logic [DenW-1:0]   o_rem
);
    localparam int unsigned StepW = $clog2(CountW) + 1;

    logic [StepW-1:0]  r_step;
    logic              r_busy, r_done;
    logic [CountW-1:0] r_quot;
    logic [DenW:0]     r_rem;
    logic [DenW-1:0]   r_dvs;
    logic [DenW:0]     w_shift;
    logic              w_ge;

    // one shift-subtract step
    assign w_shift = {r_rem[DenW-1:0], r_quot[CountW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == StepW'(CountW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[CountW-2:0], w_ge};
            r_rem  <= w_ge ? (w_shift - {1'b0, r_dvs}) : w_shift;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[DenW-1:0];
endmodule

>>> hdl/hrl_front.sv
// front: accepts items, writes the line store and classifies output positions
module hrl_front
    import hrl_pkg::*;
#(
    parameter int unsigned DEPTH = 8200
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_kind,
    input  logic [SampleW-1:0]       i_sample,
    input  logic                     i_full,
    input  logic                     i_back_idle,
    output logic                     o_push,
    output t_job                     o_job,
    output logic                     o_wr_en,
    output logic [$clog2(DEPTH)-1:0] o_wr_addr,
    output logic [SampleW-1:0]       o_wr_data
);
    localparam int unsigned AW = $clog2(DEPTH);

    logic [CountW-1:0] r_count, n_count;
    logic [AW-1:0]     r_wptr, n_wptr;
    logic [CountW-1:0] w_total, w_lag, w_pix;
    logic              w_acc, w_has_pix, w_past_end, w_last;

    // the lead-in of a frame rewrites the store from its start, so it waits for an idle back part
    assign o_ready = !i_full && (w_has_pix || i_back_idle);
    assign w_acc   = i_valid && o_ready;

    // frame size and lag
    assign w_total = CountW'(i_cfg.width) * CountW'(i_cfg.height);
    assign w_lag   = (CountW'(i_cfg.width) << 1) + CountW'(2);
    assign w_pix   = r_count - w_lag;

    assign w_has_pix  = (r_count >= w_lag);
    assign w_past_end = (w_pix >= w_total);
    assign w_last     = (w_pix == w_total - CountW'(1));

    // line store write
    assign o_wr_en   = w_acc && (r_count < w_total);
    assign o_wr_addr = r_wptr;
    assign o_wr_data = i_kind ? '0 : i_sample;

    // job for the back part
    assign o_push    = w_acc && w_has_pix && !w_past_end;
    assign o_job.pix  = w_pix;
    assign o_job.wptr = CountW'(r_wptr);
    assign o_job.last = w_last;

    // item counter and store pointer
    always_comb begin
        n_count = r_count;
        n_wptr  = r_wptr;
        if (w_acc) begin
            n_count = r_count + CountW'(1);
            n_wptr  = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            if (w_has_pix && (w_past_end || w_last)) begin
                n_count = '0;
                n_wptr  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wptr  <= '0;
        end else begin
            r_count <= n_count;
            r_wptr  <= n_wptr;
        end
    end
endmodule

>>> hdl/hrl_back.sv
// back: finds the pixel, reads the 5x5 window, forms weighted mean or centre
module hrl_back
    import hrl_pkg::*;
#(
    parameter int unsigned DEPTH = 8200
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_empty,
    input  t_job                     i_job,
    output logic                     o_pop,
    output logic                     o_idle,
    output logic                     o_rd_en,
    output logic [$clog2(DEPTH)-1:0] o_rd_addr,
    input  logic [SampleW-1:0]       i_rd_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [SampleW-1:0]       o_data,
    output logic                     o_last
);
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned OW = AW + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_POS  = 6'b000010,
        S_TAP  = 6'b000100,
        S_LAST = 6'b001000,
        S_QUO  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    t_job               r_job;
    logic [HeightW-1:0] r_row;
    logic [WidthW-1:0]  r_col;
    logic [2:0]         r_ty, r_tx;
    logic [CountW-1:0]  r_num;
    logic [DenW-1:0]    r_den;
    logic               r_pend, r_pctr, r_qgo;
    logic [WeightW-1:0] r_pwt;
    logic [SampleW-1:0] r_center;
    logic               r_ovalid, r_olast;
    logic [SampleW-1:0] r_odata;

    logic               w_div_start, w_div_busy, w_div_done;
    logic [CountW-1:0]  w_div_a, w_div_q;
    logic [DenW-1:0]    w_div_b, w_div_r;
    logic [HeightW+1:0] w_yy;
    logic [WidthW+1:0]  w_xx;
    logic               w_in;
    logic [1:0]         w_ady, w_adx;
    logic [OW-1:0]      w_off, w_diff;
    logic               w_tap_end, w_out_free;

    // shared divider: pixel position first, weighted mean second
    assign w_div_start = (r_state == S_IDLE && !i_empty) || (r_state == S_QUO && r_qgo);
    assign w_div_a     = (r_state == S_IDLE) ? i_job.pix : r_num;
    assign w_div_b     = (r_state == S_IDLE) ? DenW'(i_cfg.width) : r_den;

    hrl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_div_q),
        .o_rem      (w_div_r)
    );

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign o_idle = (r_state == S_IDLE) && i_empty;

    // tap position and frame clipping
    assign w_yy = (HeightW+2)'(r_row) + (HeightW+2)'(r_ty);
    assign w_xx = (WidthW+2)'(r_col) + (WidthW+2)'(r_tx);
    assign w_in = (w_yy >= (HeightW+2)'(2))
               && (w_yy < (HeightW+2)'(i_cfg.height) + (HeightW+2)'(2))
               && (w_xx >= (WidthW+2)'(2))
               && (w_xx < (WidthW+2)'(i_cfg.width) + (WidthW+2)'(2));
    assign w_ady = (r_ty >= 3'd2) ? 2'(r_ty - 3'd2) : 2'(3'd2 - r_ty);
    assign w_adx = (r_tx >= 3'd2) ? 2'(r_tx - 3'd2) : 2'(3'd2 - r_tx);

    // store address: current item pointer minus distance back in the raster
    assign w_off  = OW'(3'd4 - r_ty) * OW'(i_cfg.width) + OW'(3'd4 - r_tx);
    assign w_diff = OW'(r_job.wptr[AW-1:0]) - w_off;
    assign o_rd_addr = w_diff[OW-1] ? AW'(w_diff + OW'(DEPTH)) : w_diff[AW-1:0];
    assign o_rd_en   = (r_state == S_TAP);

    assign w_tap_end  = (r_ty == 3'd4) && (r_tx == 3'd4);
    assign w_out_free = !r_ovalid || i_ready;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_empty) n_state = S_POS;
            S_POS:  if (w_div_done) n_state = S_TAP;
            S_TAP:  if (w_tap_end) n_state = S_LAST;
            S_LAST: n_state = i_cfg.enable ? S_QUO : S_DONE;
            S_QUO:  if (w_div_done) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= 1'b0;
            r_qgo    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == S_TAP) && w_in;
            r_qgo   <= (r_state == S_LAST) && i_cfg.enable;
            if (r_state == S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == S_POS && w_div_done) begin
            r_row <= w_div_q[HeightW-1:0];
            r_col <= w_div_r[WidthW-1:0];
            r_ty  <= '0;
            r_tx  <= '0;
            r_num <= '0;
            r_den <= '0;
        end
        if (r_state == S_TAP) begin
            r_pwt  <= tap_weight(w_ady, w_adx);
            r_pctr <= (r_ty == 3'd2) && (r_tx == 3'd2);
            if (r_tx == 3'd4) begin
                r_tx <= '0;
                r_ty <= r_ty + 3'd1;
            end else begin
                r_tx <= r_tx + 3'd1;
            end
        end
        // accumulate the tap read in the previous cycle
        if (r_pend) begin
            r_num <= r_num + CountW'(i_rd_data) * CountW'(r_pwt);
            r_den <= r_den + DenW'(r_pwt);
            if (r_pctr) r_center <= i_rd_data;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_odata <= i_cfg.enable ? w_div_q[SampleW-1:0] : r_center;
            r_olast <= r_job.last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;

    // divider is never restarted while it works
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    // the centre tap always lands in the frame, so the weight sum is nonzero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QUO && r_qgo) |-> (r_den != '0))
        else $error("zero weight sum");

    // window reads only follow tap issue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(r_state == S_TAP))
        else $error("stray window read");

    // a result waits for the sink without being replaced
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable(r_odata)))
        else $error("result lost under stall");
endmodule

>>> hdl/heightmap_radial_lowpass_5x5_unit.sv
// top level of the 5x5 radial low-pass height filter
// lag: the job for pixel p is pushed with item p + 2*width + 2
// back part: one job at a time, in the steps pop and position divide, 25 window reads on the
//   single store read port, the final accumulate, the mean divide (skipped with the filter off)
//   and an output load that waits for the sink; items with no result are taken whenever the queue
//   has room, the first 2*width+2 of a frame only once the back part is idle
// reset: synchronous active-low; counters, queue, sequencer and configuration registers to defaults,
//   the line store is not cleared and holds no meaning until written
module heightmap_radial_lowpass_5x5_unit
    import hrl_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [15:0]  i_s_tdata,   // sample
    input  logic         i_s_tuser,   // kind
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [15:0]  o_m_tdata,   // filtered_height
    output logic         o_m_tlast
);
    localparam int unsigned DEPTH = 4 * MAX_WIDTH + 8;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic [WidthW-1:0]  r_width;
    logic [HeightW-1:0] r_height;
    logic               r_enable;
    t_cfg               w_cfg;

    logic               w_push, w_pop, w_full, w_empty, w_back_idle;
    t_job               w_job_in, w_job_out;
    logic               w_wr_en, w_rd_en;
    logic [AW-1:0]      w_wr_addr, w_rd_addr;
    logic [SampleW-1:0] w_wr_data, w_rd_data;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd1025;
            r_height <= 16'd1025;
            r_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data[WidthW-1:0];
                REG_HEIGHT: r_height <= i_cfg_data;
                REG_ENABLE: r_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp out-of-range frame sizes
    always_comb begin
        w_cfg.width  = r_width;
        if (r_width == '0) begin
            w_cfg.width = WidthW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_cfg.width = WidthW'(MAX_WIDTH);
        end
        w_cfg.height = (r_height == '0) ? HeightW'(1) : r_height;
        w_cfg.enable = r_enable;
    end

    hrl_front #(.DEPTH(DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_kind      (i_s_tuser),
        .i_sample    (i_s_tdata),
        .i_full      (w_full),
        .i_back_idle (w_back_idle),
        .o_push      (w_push),
        .o_job       (w_job_in),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

    hrl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    hrl_ram #(.WIDTH(SampleW), .DEPTH(DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    hrl_back #(.DEPTH(DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_empty   (w_empty),
        .i_job     (w_job_out),
        .o_pop     (w_pop),
        .o_idle    (w_back_idle),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata),
        .o_last    (o_m_tlast)
    );
endmodule
